/* rtl/cpwl_pkg.sv */
// ----------------------------------------------------------------------------
// cpwl_pkg
// Shared constants and elaboration-time helpers for the cell-pair
// subtree kernel: DAG shape, character codes and label lengths.
// ----------------------------------------------------------------------------
package cpwl_pkg;

	localparam int NODES        = 8;
	localparam int INNER        = 7;
	localparam int NODE_SINK    = 7;
	localparam int OP_W         = 3;
	localparam int OPS_W        = 24;
	localparam int CFG_W        = 2;
	localparam int KV_W         = 10;
	localparam int CNT_W        = 11;
	localparam int IT_W         = 3;
	localparam int LABEL_CAP    = 160;
	localparam int KERNEL_MAX   = 1023;
	localparam int MAX_ITER_DEF = 3;
	localparam logic [CFG_W-1:0] CFG_RESET = 2'd2;

	// Order-preserving character codes: '-' < digits < letters.
	localparam int CH_W      = 4;
	localparam int CH_DASH   = 0;
	localparam int CH_LETTER = 4;
	localparam int CH_SINK   = CH_LETTER + 6;

	function automatic int succ_cnt(input int i);
		case (i)
			0:       return 3;
			1:       return 2;
			default: return 1;
		endcase
	endfunction

	function automatic int succ_node(input int i, input int a);
		case (i)
			0:       return (a == 0) ? 1 : ((a == 1) ? 2 : 4);
			1:       return (a == 0) ? 3 : 5;
			2, 3:    return 6;
			default: return NODE_SINK;
		endcase
	endfunction

	function automatic int label_len(input int i, input int h);
		int len [NODES];
		int nl [NODES];
		int t;
		int c;
		for (int n = 0; n < NODES; n++) begin
			len[n] = 1;
			nl[n]  = 1;
		end
		for (int lv = 1; lv <= h; lv++) begin
			for (int n = 0; n < INNER; n++) begin
				t = len[n] + 2;
				for (int a = 0; a < succ_cnt(n); a++) begin
					c = succ_node(n, a);
					t = t + ((c == NODE_SINK) ? 1 : len[c]);
				end
				nl[n] = (t > LABEL_CAP) ? LABEL_CAP : t;
			end
			for (int n = 0; n < INNER; n++) len[n] = nl[n];
		end
		return len[i];
	endfunction

	function automatic int kid_len(input int i, input int a, input int h);
		int c;
		c = succ_node(i, a);
		if (a >= succ_cnt(i)) return 0;
		return (c == NODE_SINK) ? 1 : label_len(c, h);
	endfunction

	function automatic int perm_count(input int n);
		return (n == 3) ? 6 : ((n == 2) ? 2 : 1);
	endfunction

	function automatic int perm_elem(input int n, input int p, input int s);
		if (n == 3) begin
			case (p)
				0:       return s;
				1:       return (s == 0) ? 0 : ((s == 1) ? 2 : 1);
				2:       return (s == 0) ? 1 : ((s == 1) ? 0 : 2);
				3:       return (s == 0) ? 1 : ((s == 1) ? 2 : 0);
				4:       return (s == 0) ? 2 : ((s == 1) ? 0 : 1);
				default: return 2 - s;
			endcase
		end
		if (n == 2) return (p == 0) ? s : 1 - s;
		return 0;
	endfunction

endpackage

/* rtl/cpwl_relabel.sv */
// ----------------------------------------------------------------------------
// cpwl_relabel
// One relabeling iteration of one cell: previous label, out-degree digit,
// dash, then the successor labels in sorted order.
// ----------------------------------------------------------------------------
module cpwl_relabel #(
	parameter int LEVEL = 1,
	parameter int LW    = cpwl_pkg::label_len(0, cpwl_pkg::MAX_ITER_DEF)
) (
	input  logic [cpwl_pkg::NODES-1:0][LW-1:0][cpwl_pkg::CH_W-1:0] prev,
	output logic [cpwl_pkg::NODES-1:0][LW-1:0][cpwl_pkg::CH_W-1:0] next
);
	import cpwl_pkg::*;

	typedef logic [LW-1:0][CH_W-1:0] label_t;

	function automatic logic lex_gt(input label_t a, input int la, input label_t b,
			input int lb);
		logic res;
		logic done;
		res  = (la > lb);
		done = 1'b0;
		for (int k = 0; k < LW; k++) begin
			if (!done && k < la && k < lb && a[k] != b[k]) begin
				res  = (a[k] > b[k]);
				done = 1'b1;
			end
		end
		return res;
	endfunction

	assign next[NODE_SINK] = '0;

	for (genvar gi = 0; gi < INNER; gi++) begin : g_node
		localparam int CNT = succ_cnt(gi);
		localparam int PL  = label_len(gi, LEVEL - 1);
		localparam int NL  = label_len(gi, LEVEL);
		localparam int NP  = perm_count(CNT);
		localparam int K0  = kid_len(gi, 0, LEVEL - 1);
		localparam int K1  = kid_len(gi, 1, LEVEL - 1);
		localparam int K2  = kid_len(gi, 2, LEVEL - 1);

		label_t       kid [3];
		label_t       cand [6];
		logic   [2:0] psel;
		logic         b01;
		logic         b02;
		logic         b12;
		label_t       nl;

		always_comb begin
			for (int a = 0; a < 3; a++) begin
				kid[a] = '0;
				if (a < CNT) begin
					if (succ_node(gi, a) == NODE_SINK) kid[a][0] = CH_W'(CH_SINK);
					else kid[a] = prev[succ_node(gi, a)];
				end
			end
		end

		assign b01 = !lex_gt(kid[0], K0, kid[1], K1);
		assign b02 = !lex_gt(kid[0], K0, kid[2], K2);
		assign b12 = !lex_gt(kid[1], K1, kid[2], K2);

		always_comb begin
			psel = 3'd0;
			if (CNT == 2) begin
				psel = b01 ? 3'd0 : 3'd1;
			end else if (CNT == 3) begin
				case ({b01, b02, b12})
					3'b111:  psel = 3'd0;
					3'b110:  psel = 3'd1;
					3'b011:  psel = 3'd2;
					3'b001:  psel = 3'd3;
					3'b100:  psel = 3'd4;
					3'b000:  psel = 3'd5;
					default: psel = 3'd0;
				endcase
			end
		end

		always_comb begin
			int off;
			int e;
			int kl;
			for (int p = 0; p < 6; p++) begin
				cand[p] = '0;
				if (p < NP) begin
					for (int k = 0; k < PL; k++) cand[p][k] = prev[gi][k];
					if (PL < NL) cand[p][PL] = CH_W'(CNT);
					if (PL + 1 < NL) cand[p][PL+1] = CH_W'(CH_DASH);
					off = PL + 2;
					for (int s = 0; s < CNT; s++) begin
						e  = perm_elem(CNT, p, s);
						kl = kid_len(gi, e, LEVEL - 1);
						for (int k = 0; k < kl; k++) begin
							if (off + k < NL) cand[p][off+k] = kid[e][k];
						end
						off = off + kl;
					end
				end
			end
		end

		assign nl       = cand[psel];
		assign next[gi] = nl;
	end

endmodule

/* rtl/cell_pair_wl_subtree_kernel.sv */
// ----------------------------------------------------------------------------
// cell_pair_wl_subtree_kernel
// Subtree kernel between two 8-node cells of a fixed DAG.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries ops_first and ops_second, three op
//   bits per node. One transaction in gives one kernel_value out on
//   out_valid/out_stall.
//   Config channel cfg_valid/cfg_ready writes wl_iterations; cfg_ready is
//   always high. Write it only while the pipeline is empty.
//   Throughput: one transaction per cycle while out_stall does not hold the
//   pipeline. Depth comes from the input register, one relabeling stage per
//   iteration, a label match stage and the count/output stage.
//   Reset clears all valid bits and loads wl_iterations with 2.
//   When out_stall holds a result, stages fill up behind it; in_stall rises
//   only once every stage is occupied. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module cell_pair_wl_subtree_kernel #(
	parameter int MAX_ITERATIONS = cpwl_pkg::MAX_ITER_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [cpwl_pkg::CFG_W-1:0]  wl_iterations,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cpwl_pkg::OPS_W-1:0]  ops_first,
	input  logic [cpwl_pkg::OPS_W-1:0]  ops_second,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [cpwl_pkg::KV_W-1:0]   kernel_value
);
	import cpwl_pkg::*;

	localparam int NLV = MAX_ITERATIONS + 1;
	localparam int LW  = label_len(0, MAX_ITERATIONS);
	localparam int NST = MAX_ITERATIONS + 3;
	localparam int NM  = (NLV * NODES) * (NLV * NODES);
	localparam int SM  = MAX_ITERATIONS + 1;
	localparam int SO  = MAX_ITERATIONS + 2;

	typedef logic [NODES-1:0][LW-1:0][CH_W-1:0] cell_lab_t;

	logic [CFG_W-1:0] wl_q;
	logic [IT_W-1:0]  it_eff;
	logic [NST-1:0]   vld_s;
	logic [NST-1:0]   en;
	cell_lab_t        lab_s [NLV][2][NLV];
	cell_lab_t        nxt_lab [NLV][2];
	logic [NM-1:0]    hit;
	logic [NM-1:0]    match_s;
	logic [CNT_W-1:0] hits_n;
	logic [KV_W-1:0]  count_s;

	assign cfg_ready = 1'b1;
	assign it_eff    = (IT_W'(wl_q) > IT_W'(MAX_ITERATIONS)) ? IT_W'(MAX_ITERATIONS)
		: IT_W'(wl_q);

	always_comb begin
		en[NST-1] = !vld_s[NST-1] || !out_stall;
		for (int k = NST - 2; k >= 0; k--) en[k] = !vld_s[k] || en[k+1];
	end

	assign in_stall     = !en[0];
	assign out_valid    = vld_s[NST-1];
	assign kernel_value = count_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q  <= CFG_RESET;
			vld_s <= '0;
		end else begin
			if (cfg_valid && cfg_ready) wl_q <= wl_iterations;
			if (en[0]) vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_comb begin
		for (int n = 0; n < NODES; n++) begin
			nxt_lab[0][0][n]    = '0;
			nxt_lab[0][1][n]    = '0;
			nxt_lab[0][0][n][0] = CH_W'(CH_LETTER) + CH_W'(ops_first[OP_W*n +: OP_W]);
			nxt_lab[0][1][n][0] = CH_W'(CH_LETTER) + CH_W'(ops_second[OP_W*n +: OP_W]);
		end
	end

	for (genvar h = 1; h <= MAX_ITERATIONS; h++) begin : g_lvl
		for (genvar c = 0; c < 2; c++) begin : g_cell
			cpwl_relabel #(
				.LEVEL(h),
				.LW   (LW)
			) u_relabel (
				.prev(lab_s[h-1][c][h-1]),
				.next(nxt_lab[h][c])
			);
		end
	end

	always_ff @(posedge clk) begin
		for (int st = 0; st < NLV; st++) begin
			if (en[st]) begin
				for (int c = 0; c < 2; c++) begin
					for (int lv = 0; lv < NLV; lv++) begin
						if (lv < st) lab_s[st][c][lv] <= lab_s[(st > 0) ? st - 1 : 0][c][lv];
						else if (lv == st) lab_s[st][c][lv] <= nxt_lab[st][c];
					end
				end
			end
		end
		if (en[SM]) match_s <= hit;
		if (en[SO]) count_s <= (hits_n > CNT_W'(KERNEL_MAX)) ? KV_W'(KERNEL_MAX)
			: hits_n[KV_W-1:0];
	end

	for (genvar h1 = 0; h1 < NLV; h1++) begin : g_h1
		for (genvar i = 0; i < NODES; i++) begin : g_i
			for (genvar h2 = 0; h2 < NLV; h2++) begin : g_h2
				for (genvar j = 0; j < NODES; j++) begin : g_j
					localparam int IDX = ((h1 * NODES + i) * NLV + h2) * NODES + j;
					localparam int L1  = label_len(i, h1);
					localparam int L2  = label_len(j, h2);
					if ((h1 > 0 && i == NODE_SINK) || (h2 > 0 && j == NODE_SINK)
							|| L1 != L2) begin : g_off
						assign hit[IDX] = 1'b0;
					end else begin : g_cmp
						assign hit[IDX] = (IT_W'(h1) <= it_eff) && (IT_W'(h2) <= it_eff)
							&& (lab_s[MAX_ITERATIONS][0][h1][i][L1-1:0]
							== lab_s[MAX_ITERATIONS][1][h2][j][L1-1:0]);
					end
				end
			end
		end
	end

	assign hits_n = CNT_W'($countones(match_s));

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output is free");

	a_accept_fills_first: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_s[0])
		else $error("accepted transaction not captured");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(kernel_value)))
		else $error("stalled result changed");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for cell_pair_wl_subtree_kernel. A label-string predictor
// computes the expected kernel value for every accepted pair of cells. A
// monitor compares each result with the oldest pending value. The run
// covers directed extremes and random cell pairs under every iteration
// setting, with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import cpwl_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   wl_iterations = CFG_RESET;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [OPS_W-1:0]   ops_first = '0;
	logic [OPS_W-1:0]   ops_second = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [KV_W-1:0]    kernel_value;

	logic [KV_W-1:0]    kernel_pending[$];
	logic [CFG_W-1:0]   iter_setting = CFG_RESET;
	int                 stall_pct = 0;
	int                 mismatches = 0;
	int                 pairs_sent = 0;
	int                 results_seen = 0;

	cell_pair_wl_subtree_kernel dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .wl_iterations(wl_iterations),
		.in_valid(in_valid), .in_stall(in_stall),
		.ops_first(ops_first), .ops_second(ops_second),
		.out_valid(out_valid), .out_stall(out_stall), .kernel_value(kernel_value)
	);

	always #5 clk = ~clk;

	function automatic void build_label_list(input logic [OPS_W-1:0] ops, input int iters,
			ref string lst[$]);
		string cur[8];
		string nxt[8];
		string kid[3];
		string t;
		int n;
		int j;
		lst.delete();
		for (int k = 0; k < 8; k++) begin
			cur[k] = $sformatf("%c", 8'd97 + 8'(ops[3*k +: 3]));
			lst = {lst, cur[k]};
		end
		for (int h = 0; h < iters; h++) begin
			for (int i = 0; i < 7; i++) begin
				n = (i == 0) ? 3 : ((i == 1) ? 2 : 1);
				for (int a = 0; a < n; a++) begin
					case (i)
						0:       j = (a == 0) ? 1 : ((a == 1) ? 2 : 4);
						1:       j = (a == 0) ? 3 : 5;
						2, 3:    j = 6;
						default: j = 7;
					endcase
					kid[a] = (j == 7) ? "g" : cur[j];
				end
				for (int a = 1; a < n; a++)
					for (int b = a; b > 0 && kid[b-1] > kid[b]; b--) begin
						t = kid[b];
						kid[b] = kid[b-1];
						kid[b-1] = t;
					end
				nxt[i] = {cur[i], $sformatf("%0d-", n)};
				for (int a = 0; a < n; a++) nxt[i] = {nxt[i], kid[a]};
			end
			for (int i = 0; i < 7; i++) begin
				cur[i] = nxt[i];
				lst = {lst, cur[i]};
			end
		end
	endfunction

	function automatic logic [KV_W-1:0] subtree_kernel(input logic [OPS_W-1:0] a,
			input logic [OPS_W-1:0] b, input int iters);
		string la[$];
		string lb[$];
		int cnt;
		cnt = 0;
		build_label_list(a, iters, la);
		build_label_list(b, iters, lb);
		foreach (la[p]) foreach (lb[q]) if (la[p] == lb[q]) cnt++;
		if (cnt > KERNEL_MAX) cnt = KERNEL_MAX;
		return KV_W'(cnt);
	endfunction

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send_pair(input logic [OPS_W-1:0] a, input logic [OPS_W-1:0] b,
			input bit use_gap);
		int gap;
		gap = use_gap ? rand_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		ops_first  <= a;
		ops_second <= b;
		do @(posedge clk); while (in_stall);
		kernel_pending = {kernel_pending, subtree_kernel(a, b, int'(iter_setting))};
		pairs_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (kernel_pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_iterations(input logic [CFG_W-1:0] v);
		drain();
		cfg_valid     <= 1'b1;
		wl_iterations <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		iter_setting = v;
	endtask

	// near copies of a cell make long labels match
	function automatic logic [OPS_W-1:0] mutate(input logic [OPS_W-1:0] a);
		logic [OPS_W-1:0] r;
		r = a;
		if ($urandom_range(0, 1)) r[3*$urandom_range(0, 7) +: 3] = 3'($urandom);
		return r;
	endfunction

	task automatic test_directed();
		for (int it = 0; it < 4; it++) begin
			write_iterations(CFG_W'(it));
			send_pair('0, '0, 1'b0);
			send_pair('1, '1, 1'b0);
			send_pair('0, '1, 1'b0);
			send_pair(24'hFAC688, 24'hFAC688, 1'b0);
			send_pair(24'hFAC688, 24'h053977, 1'b1);
			send_pair(24'h6DB6DB, 24'hB6DB6D, 1'b1);
		end
		for (int op = 0; op < 8; op++)
			send_pair({8{3'(op)}}, {8{3'(7 - op)}}, 1'b0);
	endtask

	task automatic test_random(input logic [CFG_W-1:0] it, input int count);
		logic [OPS_W-1:0] a;
		logic [OPS_W-1:0] b;
		write_iterations(it);
		for (int n = 0; n < count; n++) begin
			a = 24'($urandom);
			case ($urandom_range(0, 3))
				0:       b = a;
				1:       b = mutate(mutate(a));
				2:       b = {8{3'($urandom)}} ^ (24'($urandom) & 24'h00F00F);
				default: b = 24'($urandom);
			endcase
			if ($urandom_range(0, 1)) send_pair(a, b, 1'b1);
			else send_pair(b, a, 1'b1);
		end
	endtask

	task automatic test_backpressure();
		stall_pct = 70;
		for (int n = 0; n < 40; n++) send_pair(24'($urandom), mutate(24'($urandom)), 1'b0);
		drain();
		stall_pct = 0;
		for (int n = 0; n < 40; n++) send_pair(24'($urandom), 24'($urandom), 1'b0);
		stall_pct = 25;
	endtask

	always @(posedge clk) begin
		if (stall_pct == 0) out_stall <= 1'b0;
		else if ($urandom_range(0, 99) < 3) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (kernel_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result kernel_value=%0d", kernel_value);
			end else begin
				if (kernel_value !== kernel_pending[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch kernel_value: expected %0d actual %0d",
							kernel_pending[0], kernel_value);
				end
				void'(kernel_pending.pop_front());
			end
		end
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		stall_pct = 25;
		test_directed();
		test_random(2'd0, 150);
		test_random(2'd3, 200);
		test_backpressure();
		test_random(2'd1, 150);
		test_random(2'd2, 200);
		drain();
		$display("Covered %0d cell pairs, %0d results, iterations 0..3, gaps and stalls.",
			pairs_sent, results_seen);
		if (mismatches == 0 && kernel_pending.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, kernel_pending.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/cpwl_pkg.sv
rtl/cpwl_relabel.sv
rtl/cell_pair_wl_subtree_kernel.sv
tb/tb.sv
